// File: rtl/core/psfrm_pkg.sv
// ----------------------------------------------------------------------------
// psfrm_pkg
// Shared types and constants of the page skip filter with skipped-range map.
// ----------------------------------------------------------------------------
package psfrm_pkg;

  localparam logic CFG_SYSTEM_SPACE = 1'b0;
  localparam logic CFG_INDEX_TYPE   = 1'b1;

  localparam logic ACTION_PAGE   = 1'b0;
  localparam logic ACTION_FINISH = 1'b1;

  localparam logic KIND_START = 1'b0;
  localparam logic KIND_END   = 1'b1;

  localparam logic [15:0] INDEX_TYPE_RESET = 16'd17855;

  typedef struct packed {
    logic        finish;
    logic        page_zero;
    logic        root_page;
    logic        index_page;
    logic        seg_clear;
    logic [31:0] page_no;
    logic [31:0] end_value;
    logic [31:0] limit_word;
    logic [63:0] id_word;
  } psfrm_item_t;

endpackage

// File: rtl/core/psfrm_front.sv
// ----------------------------------------------------------------------------
// psfrm_front
// Classifies an incoming page item into a compact record for the back end.
// ----------------------------------------------------------------------------
module psfrm_front
  import psfrm_pkg::*;
#(
  parameter int ROOT_PAGE_NUMBER = 3
) (
  input  logic        action,
  input  logic [31:0] page_no,
  input  logic [15:0] hdr_page_type,
  input  logic [31:0] header_free_limit,
  input  logic [63:0] hdr_index_id,
  input  logic [31:0] seg_space,
  input  logic [31:0] seg_page,
  input  logic [15:0] seg_offset,
  input  logic [32:0] total_pages,
  input  logic [15:0] index_type_code,
  output psfrm_item_t item
);

  always_comb begin
    item.finish     = (action == ACTION_FINISH);
    item.page_zero  = (page_no == 32'd0);
    item.root_page  = (page_no == 32'(ROOT_PAGE_NUMBER));
    item.index_page = (hdr_page_type == index_type_code);
    item.seg_clear  = (seg_space == 32'd0) && (seg_page == 32'd0) && (seg_offset == 16'd0);
    item.page_no    = page_no;
    item.end_value  = (action == ACTION_FINISH) ? (total_pages[31:0] - 32'd1)
                                                : (page_no - 32'd1);
    item.limit_word = header_free_limit;
    item.id_word    = hdr_index_id;
  end

endmodule

// File: rtl/core/psfrm_queue.sv
// ----------------------------------------------------------------------------
// psfrm_queue
// Two-entry queue between the classifier and the decision stage.
// ----------------------------------------------------------------------------
module psfrm_queue
  import psfrm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  psfrm_item_t push_item,
  output logic        full,
  input  logic        pop,
  output logic        head_valid,
  output psfrm_item_t head_item
);

  psfrm_item_t entries [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;

  assign full       = (count == 2'd2);
  assign head_valid = (count != 2'd0);
  assign head_item  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// File: rtl/core/psfrm_back.sv
// ----------------------------------------------------------------------------
// psfrm_back
// Holds the tablespace state, decides keep or skip and registers the result.
// ----------------------------------------------------------------------------
module psfrm_back
  import psfrm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        system_space,
  input  logic        system_space_load,
  input  logic        head_valid,
  input  psfrm_item_t head_item,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        keep_page,
  output logic        map_valid,
  output logic [31:0] map_value,
  output logic        map_kind
);

  logic [31:0] free_limit_seen;
  logic        clustered_found;
  logic [63:0] clustered_id;
  logic        in_skipped_run;
  logic        pass_through;

  logic        skip;
  logic        keep_next;
  logic        map_valid_next;
  logic [31:0] map_value_next;
  logic        map_kind_next;

  assign pop = head_valid && (!out_valid || out_ready);

  always_comb begin
    if (head_item.page_zero || head_item.root_page) begin
      skip = 1'b0;
    end else if (head_item.page_no >= free_limit_seen) begin
      skip = (free_limit_seen != 32'd0);
    end else begin
      skip = clustered_found && head_item.index_page &&
             (head_item.id_word != clustered_id) && head_item.seg_clear;
    end
  end

  always_comb begin
    keep_next      = 1'b1;
    map_valid_next = 1'b0;
    map_value_next = 32'd0;
    map_kind_next  = KIND_START;
    if (head_item.finish) begin
      keep_next = 1'b0;
      if (in_skipped_run) begin
        map_valid_next = 1'b1;
        map_value_next = head_item.end_value;
        map_kind_next  = KIND_END;
      end
    end else if (pass_through) begin
      keep_next = 1'b1;
    end else if (!skip) begin
      if (in_skipped_run) begin
        map_valid_next = 1'b1;
        map_value_next = head_item.end_value;
        map_kind_next  = KIND_END;
      end
    end else begin
      keep_next = 1'b0;
      if (!in_skipped_run) begin
        map_valid_next = 1'b1;
        map_value_next = head_item.page_no;
        map_kind_next  = KIND_START;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      free_limit_seen <= 32'd0;
      clustered_found <= 1'b0;
      clustered_id    <= 64'd0;
      in_skipped_run  <= 1'b0;
      pass_through    <= 1'b0;
    end else if (pop) begin
      if (head_item.finish) begin
        free_limit_seen <= 32'd0;
        clustered_found <= 1'b0;
        clustered_id    <= 64'd0;
        in_skipped_run  <= 1'b0;
        pass_through    <= system_space;
      end else if (!pass_through) begin
        if (head_item.page_zero) begin
          free_limit_seen <= head_item.limit_word;
        end else if (head_item.root_page) begin
          if (!head_item.index_page) begin
            pass_through <= 1'b1;
          end else begin
            clustered_id    <= head_item.id_word;
            clustered_found <= 1'b1;
          end
        end
        in_skipped_run <= skip;
      end
    end else if (system_space_load) begin
      pass_through <= system_space;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      keep_page <= keep_next;
      map_valid <= map_valid_next;
      map_value <= map_value_next;
      map_kind  <= map_kind_next;
    end
  end

endmodule

// File: rtl/core/page_skip_filter_range_map.sv
// ----------------------------------------------------------------------------
// page_skip_filter_range_map
// Page skip filter: keeps or skips tablespace pages and reports skipped runs.
// ----------------------------------------------------------------------------
// One page item is accepted per cycle, sustained, while the queue has room
// and the output side is not stalled. An accepted item is classified, written
// into a two-entry queue and taken from it by the decision stage once the
// output register is free; the result is registered. The decision stage (a
// 32-bit free limit compare and a 64-bit index id compare against held state)
// is combinational, which gives the rate of one item per cycle. Each item
// yields exactly one result. Configuration is written through its own port,
// always ready, and must only be written while the block is idle.
// ----------------------------------------------------------------------------
module page_skip_filter_range_map
  import psfrm_pkg::*;
#(
  parameter int ROOT_PAGE_NUMBER = 3
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        action,
  input  logic [31:0] page_no,
  input  logic [15:0] hdr_page_type,
  input  logic [31:0] header_free_limit,
  input  logic [63:0] hdr_index_id,
  input  logic [31:0] seg_space,
  input  logic [31:0] seg_page,
  input  logic [15:0] seg_offset,
  input  logic [32:0] total_pages,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        keep_page,
  output logic        map_valid,
  output logic [31:0] map_value,
  output logic        map_kind
);

  logic        system_space;
  logic [15:0] index_type_code;
  logic        cfg_write;
  logic        system_space_load;

  psfrm_item_t front_item;
  psfrm_item_t head_item;
  logic        q_full;
  logic        q_valid;
  logic        pop;
  logic        push;

  assign cfg_ready         = 1'b1;
  assign cfg_write         = cfg_valid && cfg_ready;
  assign system_space_load = cfg_write && (cfg_index == CFG_SYSTEM_SPACE);

  always_ff @(posedge clk) begin
    if (rst) begin
      system_space    <= 1'b0;
      index_type_code <= INDEX_TYPE_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_SYSTEM_SPACE: system_space    <= cfg_data[0];
        CFG_INDEX_TYPE:   index_type_code <= cfg_data;
        default:          system_space    <= system_space;
      endcase
    end
  end

  assign in_ready = !q_full;
  assign push     = in_valid && in_ready;

  psfrm_front #(
    .ROOT_PAGE_NUMBER(ROOT_PAGE_NUMBER)
  ) u_front (
    .action           (action),
    .page_no          (page_no),
    .hdr_page_type    (hdr_page_type),
    .header_free_limit(header_free_limit),
    .hdr_index_id     (hdr_index_id),
    .seg_space        (seg_space),
    .seg_page         (seg_page),
    .seg_offset       (seg_offset),
    .total_pages      (total_pages),
    .index_type_code  (index_type_code),
    .item             (front_item)
  );

  psfrm_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (front_item),
    .full      (q_full),
    .pop       (pop),
    .head_valid(q_valid),
    .head_item (head_item)
  );

  psfrm_back u_back (
    .clk              (clk),
    .rst              (rst),
    .system_space     (system_space_load ? cfg_data[0] : system_space),
    .system_space_load(system_space_load),
    .head_valid       (q_valid),
    .head_item        (head_item),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .keep_page        (keep_page),
    .map_valid        (map_valid),
    .map_value        (map_value),
    .map_kind         (map_kind)
  );

  a_push_fills_queue: assert property (@(posedge clk) disable iff (rst)
    push |=> q_valid)
    else $error("queue empty after an item was pushed");

  a_drain_clears_output: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !q_valid |=> !out_valid)
    else $error("result shown again with no item queued");

  a_no_endpoint_clear: assert property (@(posedge clk) disable iff (rst)
    out_valid && !map_valid |-> (map_value == 32'd0) && (map_kind == KIND_START))
    else $error("endpoint fields not clear without an endpoint");

  a_start_is_skip: assert property (@(posedge clk) disable iff (rst)
    out_valid && map_valid && (map_kind == KIND_START) |-> !keep_page)
    else $error("run start reported on a kept page");

endmodule

// File: test/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the page skip filter with skipped-range map.
// Pages are fed through the valid/ready input channel from a queue. Each
// accepted item is run through a behavioural filter kept inside the bench,
// and each result leaving the block is checked against the oldest
// prediction. Configuration changes happen only between phases, once the
// block has gone quiet.
// ----------------------------------------------------------------------------
module tb;
  import psfrm_pkg::*;

  localparam int          ROOT_PAGE = 3;
  localparam longint      LIMIT     = 200000;

  typedef struct packed {
    logic        action;
    logic [31:0] page_no;
    logic [15:0] hdr_type;
    logic [31:0] limit_word;
    logic [63:0] id_word;
    logic [31:0] seg_space;
    logic [31:0] seg_page;
    logic [15:0] seg_offset;
    logic [32:0] pages_total;
  } page_item_t;

  typedef struct packed {
    logic        keep;
    logic        mvalid;
    logic [31:0] mvalue;
    logic        mkind;
  } page_verdict_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = 1'b0;
  logic [15:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        action = 1'b0;
  logic [31:0] page_no = '0;
  logic [15:0] hdr_page_type = '0;
  logic [31:0] header_free_limit = '0;
  logic [63:0] hdr_index_id = '0;
  logic [31:0] seg_space = '0;
  logic [31:0] seg_page = '0;
  logic [15:0] seg_offset = '0;
  logic [32:0] total_pages = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        keep_page;
  logic        map_valid;
  logic [31:0] map_value;
  logic        map_kind;

  page_skip_filter_range_map dut (
    .clk              (clk),
    .rst              (rst),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .action           (action),
    .page_no          (page_no),
    .hdr_page_type    (hdr_page_type),
    .header_free_limit(header_free_limit),
    .hdr_index_id     (hdr_index_id),
    .seg_space        (seg_space),
    .seg_page         (seg_page),
    .seg_offset       (seg_offset),
    .total_pages      (total_pages),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .keep_page        (keep_page),
    .map_valid        (map_valid),
    .map_value        (map_value),
    .map_kind         (map_kind)
  );

  // filter state mirrored in the bench
  logic        sys_space   = 1'b0;
  logic [15:0] type_code   = INDEX_TYPE_RESET;
  logic [31:0] free_lim    = '0;
  logic        clust_found = 1'b0;
  logic [63:0] clust_id    = '0;
  logic        run_open    = 1'b0;
  logic        bypass      = 1'b0;

  page_item_t    pending_pages[$];
  page_verdict_t verdict_q[$];
  page_item_t    offered;

  int     n_queued       = 0;
  int     n_accepted     = 0;
  int     n_checked      = 0;
  int     err_cnt        = 0;
  int     send_idle_pct  = 0;
  int     recv_stall_pct = 0;
  int     hold_left      = 0;
  logic   hold_done      = 1'b0;
  longint cycles         = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic page_verdict_t filter_page(page_item_t it);
    page_verdict_t v;
    logic          skip;
    logic [32:0]   last;
    v = '0;
    if (it.action == ACTION_FINISH) begin
      if (run_open) begin
        last = it.pages_total - 33'd1;
        v = '{1'b0, 1'b1, last[31:0], KIND_END};
      end
      free_lim    = '0;
      clust_found = 1'b0;
      clust_id    = '0;
      run_open    = 1'b0;
      bypass      = sys_space;
      return v;
    end
    if (bypass) begin
      v.keep = 1'b1;
      return v;
    end
    skip = 1'b0;
    if (it.page_no == 32'd0) begin
      free_lim = it.limit_word;
    end else if (it.page_no == ROOT_PAGE) begin
      if (it.hdr_type != type_code) begin
        bypass = 1'b1;
      end else begin
        clust_id    = it.id_word;
        clust_found = 1'b1;
      end
    end else if (it.page_no >= free_lim) begin
      skip = (free_lim != 32'd0);
    end else if (clust_found && it.hdr_type == type_code && it.id_word != clust_id) begin
      skip = (it.seg_space == 32'd0) && (it.seg_page == 32'd0) && (it.seg_offset == 16'd0);
    end
    if (!skip) begin
      v.keep = 1'b1;
      if (run_open) begin
        run_open = 1'b0;
        v.mvalid = 1'b1;
        v.mvalue = it.page_no - 32'd1;
        v.mkind  = KIND_END;
      end
    end else if (!run_open) begin
      run_open = 1'b1;
      v.mvalid = 1'b1;
      v.mvalue = it.page_no;
      v.mkind  = KIND_START;
    end
    return v;
  endfunction

  task automatic queue_page(logic act, logic [31:0] pno, logic [15:0] ptype, logic [31:0] lim,
                            logic [63:0] id, logic [31:0] ss, logic [31:0] sp, logic [15:0] so,
                            logic [32:0] size);
    pending_pages.push_back('{act, pno, ptype, lim, id, ss, sp, so, size});
    n_queued++;
  endtask

  // one tablespace: page 0, a run of pages, then the finish item
  task automatic queue_tablespace(output int n);
    int          len;
    logic [31:0] lim;
    logic [31:0] pno;
    logic [15:0] ptype;
    logic [63:0] own_id;
    logic [63:0] other_id;
    logic [63:0] id;
    logic [31:0] ss;
    logic [31:0] sp;
    logic [15:0] so;
    logic        root_ok;
    logic [32:0] size;
    len      = $urandom_range(3, 40);
    own_id   = {$urandom, $urandom};
    other_id = {$urandom, $urandom};
    lim      = ($urandom_range(0, 3) == 0) ? 32'd0 : 32'($urandom_range(2, len + 4));
    root_ok  = ($urandom_range(0, 9) != 0);
    queue_page(ACTION_PAGE, 32'd0, 16'($urandom), lim, {$urandom, $urandom}, $urandom,
               $urandom, 16'($urandom), 33'($urandom));
    for (int p = 1; p <= len; p++) begin
      case ($urandom_range(0, 29))
        0:       pno = $urandom;
        1, 2:    pno = $urandom_range(0, len + 4);
        default: pno = p;
      endcase
      ptype = ($urandom_range(0, 9) < 7) ? type_code : 16'($urandom);
      if (pno == ROOT_PAGE)
        ptype = root_ok ? type_code : type_code ^ (16'd1 << $urandom_range(0, 15));
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: id = own_id;
        5, 6, 7, 8:    id = other_id;
        default:       id = {$urandom, $urandom};
      endcase
      if ($urandom_range(0, 9) < 6) begin
        ss = '0;
        sp = '0;
        so = '0;
      end else begin
        ss = $urandom_range(0, 1) ? $urandom : 32'd0;
        sp = $urandom_range(0, 1) ? $urandom : 32'd0;
        so = $urandom_range(0, 1) ? 16'($urandom) : 16'd0;
      end
      queue_page(ACTION_PAGE, pno, ptype, $urandom, id, ss, sp, so, 33'($urandom));
    end
    size = ($urandom_range(0, 3) == 0) ? {1'b0, $urandom} + 33'd1
                                       : 33'(len + $urandom_range(1, 8));
    queue_page(ACTION_FINISH, $urandom, 16'($urandom), $urandom, {$urandom, $urandom},
               $urandom, $urandom, 16'($urandom), size);
    n = len + 2;
  endtask

  task automatic queue_random(int count);
    int n;
    logic [32:0] size;
    while (count > 0) begin
      if ($urandom_range(0, 9) == 0) begin
        size = {1'b0, $urandom} + 33'd1;
        queue_page($urandom_range(0, 7) == 0,
                   $urandom_range(0, 3) == 0 ? $urandom : 32'($urandom_range(0, 12)),
                   $urandom_range(0, 1) ? type_code : 16'($urandom), $urandom,
                   {$urandom, $urandom}, $urandom_range(0, 1) ? $urandom : 32'd0,
                   $urandom_range(0, 1) ? $urandom : 32'd0,
                   $urandom_range(0, 1) ? 16'($urandom) : 16'd0, size);
        count--;
      end else begin
        queue_tablespace(n);
        count -= n;
      end
    end
  endtask

  task automatic write_reg(logic idx, logic [15:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_SYSTEM_SPACE) begin
      sys_space = data[0];
      bypass    = data[0];
    end else begin
      type_code = data;
    end
  endtask

  task automatic wait_drained();
    while (n_accepted != n_queued || verdict_q.size() != 0) @(posedge clk);
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        verdict_q.push_back(filter_page(offered));
        n_accepted++;
      end
      if (!in_valid || in_ready) begin
        if (pending_pages.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          offered = pending_pages.pop_front();
          in_valid          <= 1'b1;
          action            <= offered.action;
          page_no           <= offered.page_no;
          hdr_page_type     <= offered.hdr_type;
          header_free_limit <= offered.limit_word;
          hdr_index_id      <= offered.id_word;
          seg_space         <= offered.seg_space;
          seg_page          <= offered.seg_page;
          seg_offset        <= offered.seg_offset;
          total_pages       <= offered.pages_total;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver, with one long hold-off so the block backs up
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && n_checked >= 40) begin
      hold_done <= 1'b1;
      hold_left <= 300;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // monitor
  always @(posedge clk) begin
    page_verdict_t got;
    page_verdict_t want;
    if (!rst && out_valid && out_ready) begin
      got = '{keep_page, map_valid, map_value, map_kind};
      n_checked++;
      if (verdict_q.size() == 0) begin
        err_cnt++;
        $display("%0t: result with nothing expected, actual keep=%0b map=%0b value=%h kind=%0b",
                 $time, got.keep, got.mvalid, got.mvalue, got.mkind);
      end else begin
        want = verdict_q.pop_front();
        if (got !== want) begin
          err_cnt++;
          $display("%0t: expected k=%0b m=%0b v=%h t=%0b, actual k=%0b m=%0b v=%h t=%0b",
                   $time, want.keep, want.mvalid, want.mvalue, want.mkind,
                   got.keep, got.mvalid, got.mvalue, got.mkind);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("[page_skip_filter_range_map] ERROR");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    write_reg(CFG_SYSTEM_SPACE, 16'd0);
    write_reg(CFG_INDEX_TYPE, INDEX_TYPE_RESET);
    send_idle_pct  = 0;
    recv_stall_pct = 0;

    queue_page(ACTION_PAGE, 32'd0, 16'd0, 32'd10, 64'd0, 32'd0, 32'd0, 16'd0, 33'd1);
    queue_page(ACTION_PAGE, 32'd1, 16'hFFFF, 32'hFFFF_FFFF, '1, '1, '1, '1, 33'h1_0000_0000);
    queue_page(ACTION_PAGE, 32'd3, INDEX_TYPE_RESET, 32'd0, 64'd100, 32'd0, 32'd0, 16'd0, 33'd1);
    queue_page(ACTION_PAGE, 32'd4, INDEX_TYPE_RESET, 32'd0, 64'd200, 32'd0, 32'd0, 16'd0, 33'd1);
    queue_page(ACTION_PAGE, 32'd5, INDEX_TYPE_RESET, 32'd0, 64'd200, 32'd0, 32'd0, 16'd1, 33'd1);
    queue_page(ACTION_PAGE, 32'd6, INDEX_TYPE_RESET, 32'd0, 64'd100, 32'd0, 32'd0, 16'd0, 33'd1);
    queue_page(ACTION_PAGE, 32'd10, INDEX_TYPE_RESET, 32'd0, 64'd100, 32'd0, 32'd0, 16'd0, 33'd1);
    queue_page(ACTION_PAGE, '1, INDEX_TYPE_RESET, 32'd0, 64'd100, 32'd0, 32'd0, 16'd0, 33'd1);
    // page 0 out of order closes the run one below page 0
    queue_page(ACTION_PAGE, 32'd0, 16'd0, '1, 64'd0, 32'd0, 32'd0, 16'd0, 33'd1);
    queue_page(ACTION_PAGE, 32'd3, INDEX_TYPE_RESET, 32'd0, '1, 32'd0, 32'd0, 16'd0, 33'd1);
    queue_page(ACTION_PAGE, 32'd7, INDEX_TYPE_RESET, 32'd0, 64'd100, 32'd0, 32'd0, 16'd0, 33'd1);
    queue_page(ACTION_PAGE, 32'd8, INDEX_TYPE_RESET, 32'd0, '1, 32'd0, 32'd0, 16'd0, 33'd1);
    queue_page(ACTION_PAGE, 32'd9, INDEX_TYPE_RESET, 32'd0, 64'd5, 32'd0, 32'd0, 16'd0, 33'd1);
    queue_page(ACTION_FINISH, 32'd0, 16'd0, 32'd0, 64'd0, 32'd0, 32'd0, 16'd0, 33'd0);
    queue_page(ACTION_PAGE, 32'd0, 16'd0, 32'd1, 64'd0, 32'd0, 32'd0, 16'd0, 33'd1);
    queue_page(ACTION_PAGE, 32'd1, 16'd0, 32'd0, 64'd0, 32'd0, 32'd0, 16'd0, 33'd1);
    queue_page(ACTION_FINISH, 32'd0, 16'd0, 32'd0, 64'd0, 32'd0, 32'd0, 16'd0, 33'h1_0000_0000);
    queue_page(ACTION_PAGE, 32'd5, 16'd0, 32'd0, 64'd0, 32'd0, 32'd0, 16'd0, 33'd1);
    queue_page(ACTION_FINISH, 32'd0, 16'd0, 32'd0, 64'd0, 32'd0, 32'd0, 16'd0, 33'd1);
    // root page that is not an index page switches to pass-through
    queue_page(ACTION_PAGE, 32'd0, 16'd0, 32'd2, 64'd0, 32'd0, 32'd0, 16'd0, 33'd1);
    queue_page(ACTION_PAGE, 32'd2, 16'd0, 32'd0, 64'd0, 32'd0, 32'd0, 16'd0, 33'd1);
    queue_page(ACTION_PAGE, 32'd3, 16'hFFFF, 32'd0, 64'd0, 32'd0, 32'd0, 16'd0, 33'd1);
    queue_page(ACTION_PAGE, 32'd9, INDEX_TYPE_RESET, 32'd0, 64'd7, 32'd0, 32'd0, 16'd0, 33'd1);
    queue_page(ACTION_FINISH, 32'd0, 16'd0, 32'd0, 64'd0, 32'd0, 32'd0, 16'd0, 33'd7);
    queue_random(300);
    // leave a run open going into pass-through
    queue_page(ACTION_PAGE, 32'd0, 16'd0, 32'd1, 64'd0, 32'd0, 32'd0, 16'd0, 33'd1);
    queue_page(ACTION_PAGE, 32'd1, 16'd0, 32'd0, 64'd0, 32'd0, 32'd0, 16'd0, 33'd1);
    wait_drained();

    write_reg(CFG_SYSTEM_SPACE, 16'd1);
    write_reg(CFG_INDEX_TYPE, 16'd0);
    send_idle_pct  = 67;
    recv_stall_pct = 0;
    queue_random(150);
    wait_drained();

    write_reg(CFG_SYSTEM_SPACE, 16'd0);
    write_reg(CFG_INDEX_TYPE, 16'hFFFF);
    send_idle_pct  = 0;
    recv_stall_pct = 67;
    queue_random(350);
    wait_drained();

    write_reg(CFG_SYSTEM_SPACE, 16'd0);
    write_reg(CFG_INDEX_TYPE, INDEX_TYPE_RESET);
    send_idle_pct  = 8;
    recv_stall_pct = 8;
    queue_random(450);
    wait_drained();

    repeat (10) @(posedge clk);
    if (err_cnt == 0 && verdict_q.size() == 0) begin
      $display("[page_skip_filter_range_map] OK");
    end else begin
      $display("[page_skip_filter_range_map] ERROR");
    end
    $finish;
  end

endmodule
